@@ sv/buddy_page_allocator_assert.svh @@
`ifndef BUDDY_PAGE_ALLOCATOR_ASSERT_SVH
`define BUDDY_PAGE_ALLOCATOR_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define BPA_ASSERT_NOW(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("buddy allocator check failed");

// next-cycle implication, disabled while in reset
`define BPA_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("buddy allocator check failed");

`endif

@@ sv/bpa_pkg.sv @@
`timescale 1ns / 1ps

package bpa_pkg;

  // default sizes
  localparam int NUM_PAGES_DEF  = 4096;
  localparam int NUM_ORDERS_DEF = 11;

  // fixed field widths
  localparam int CMD_W     = 2;
  localparam int CNT_W     = 13;
  localparam int IDX_W     = 12;
  localparam int STAT_W    = 2;
  localparam int ORD_W     = 4;
  localparam int REG_W     = 13;
  localparam int CFG_IDX_W = 1;
  localparam int WANT_W    = 4;

  // command codes
  localparam logic [CMD_W-1:0] CMD_INIT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_BLOCK  = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_ALLOC = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_REGION_BEGIN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_END   = 1'b1;

  localparam logic [REG_W-1:0] REGION_END_RST = 13'd4096;

  // datapath micro-operations
  typedef enum logic [4:0] {
    OP_IDLE,
    OP_LOAD,
    OP_CLR,
    OP_I_BOUNDS,
    OP_I_TOP,
    OP_I_DEC,
    OP_I_GO,
    OP_R_READ,
    OP_R_UNLINK,
    OP_PUSH1,
    OP_PUSH2,
    OP_A_SEARCH,
    OP_A_READ,
    OP_A_UNLINK,
    OP_SPLIT,
    OP_F_READ,
    OP_F_BAD,
    OP_F_CLEAR,
    OP_EMIT
  } dp_op_e;

  // datapath conditions seen by the controller
  typedef struct packed {
    logic clr_last;
    logic init_more;
    logic init_fit;
    logic can_try;
    logic buddy_match;
    logic alloc_fail;
    logic k_gt_want;
    logic idx_bad;
    logic page_used;
    logic out_busy;
  } dp_stat_t;

endpackage

@@ sv/bpa_ram.sv @@
`timescale 1ns / 1ps

module bpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // single port, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/bpa_dp.sv @@
`timescale 1ns / 1ps

module bpa_dp import bpa_pkg::*; #(
  parameter int NUM_PAGES  = NUM_PAGES_DEF,
  parameter int NUM_ORDERS = NUM_ORDERS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dp_op_e               op_i,
  output dp_stat_t             stat_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [REG_W-1:0]     cfg_data_i,
  input  logic [CMD_W-1:0]     command_i,
  input  logic [CNT_W-1:0]     page_count_i,
  input  logic [IDX_W-1:0]     page_index_i,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output logic [STAT_W-1:0]    status_o,
  output logic [IDX_W-1:0]     block_page_o,
  output logic [ORD_W-1:0]     block_order_o,
  output logic [CNT_W-1:0]     free_pages_o
);

  localparam int AW = $clog2(NUM_PAGES);
  localparam int PW = $clog2(NUM_PAGES + 1);
  localparam int KW = $clog2(NUM_ORDERS);
  localparam int MW = KW + 2;
  localparam logic [PW-1:0] NIL = PW'(NUM_PAGES);

  typedef struct packed {
    logic          used;
    logic          fhead;
    logic [KW-1:0] order;
  } meta_t;

  // registers
  logic [REG_W-1:0]  begin_q, end_q;
  logic [CMD_W-1:0]  cmd_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [IDX_W-1:0]  idx_q;
  logic [PW-1:0]     clr_q;
  logic [PW-1:0]     b_q, e_q;
  logic [KW-1:0]     ik_q;
  logic [PW-1:0]     p_q;
  logic [KW-1:0]     k_q;
  logic [KW-1:0]     want_q;
  logic [PW-1:0]     base_q;
  logic [PW-1:0]     h_q;
  logic [PW-1:0]     head_q [NUM_ORDERS];
  logic [PW-1:0]     total_q;
  logic [STAT_W-1:0] res_st_q;
  logic [IDX_W-1:0]  res_bp_q;
  logic [ORD_W-1:0]  res_bk_q;
  logic              out_valid_q;
  logic [STAT_W-1:0] status_q;
  logic [IDX_W-1:0]  bp_q;
  logic [ORD_W-1:0]  bk_q;
  logic [CNT_W-1:0]  fp_q;

  // memory ports
  logic          m_we, n_we, v_we;
  logic [AW-1:0] m_addr, n_addr, v_addr;
  meta_t         m_wd;
  logic [PW-1:0] n_wd, v_wd;
  logic [MW-1:0] m_rd;
  logic [PW-1:0] rd_next, rd_prev;
  meta_t         rd_meta;

  // derived values
  logic [WANT_W-1:0] msb_c, want_c;
  logic              want_bad, found;
  logic [KW-1:0]     fk;
  logic [KW-1:0]     tz;
  logic [31:0]       buddy32;
  logic [PW-1:0]     buddy;
  logic [PW-1:0]     pow_k, pow_km1, pow_ik;
  logic [PW-1:0]     head_k;
  logic [PW-1:0]     b_clamp, e_clamp;
  logic [KW-1:0]     ord_clamp;
  logic [AW-1:0]     idx_a;

  assign rd_meta = meta_t'(m_rd);
  assign head_k  = head_q[k_q];
  assign idx_a   = AW'(idx_q);

  // rounded order of the requested page count
  always_comb begin
    msb_c = '0;
    for (int i = 0; i < CNT_W; i++) begin
      if (cnt_q[i]) begin
        msb_c = WANT_W'(i);
      end
    end
    if (cnt_q <= CNT_W'(1)) begin
      want_c = '0;
    end else if ((cnt_q & (cnt_q - CNT_W'(1))) == '0) begin
      want_c = msb_c;
    end else begin
      want_c = msb_c + WANT_W'(1);
    end
  end

  assign want_bad = 32'(want_c) >= NUM_ORDERS;

  // smallest non-empty order at or above the wanted one
  always_comb begin
    found = 1'b0;
    fk    = '0;
    for (int i = 0; i < NUM_ORDERS; i++) begin
      if (!found && i >= int'(want_c) && head_q[i] != NIL) begin
        found = 1'b1;
        fk    = KW'(i);
      end
    end
  end

  // alignment order of the init cursor, capped at the top order
  always_comb begin
    tz = KW'(NUM_ORDERS - 1);
    for (int i = NUM_ORDERS - 2; i >= 0; i--) begin
      if (((32'(b_q) >> i) & 32'd1) == 32'd1) begin
        tz = KW'(i);
      end
    end
  end

  assign buddy32 = 32'(p_q) ^ (32'd1 << k_q);
  assign buddy   = PW'(buddy32);
  assign pow_k   = PW'(32'd1 << k_q);
  assign pow_km1 = PW'(32'd1 << (32'(k_q) - 32'd1));
  assign pow_ik  = PW'(32'd1 << ik_q);
  assign b_clamp = (32'(begin_q) > NUM_PAGES) ? NIL : PW'(begin_q);
  assign e_clamp = (32'(end_q) > NUM_PAGES) ? NIL : PW'(end_q);
  assign ord_clamp = (32'(rd_meta.order) >= NUM_ORDERS) ? KW'(NUM_ORDERS - 1)
                                                         : rd_meta.order;

  // status toward the controller
  always_comb begin
    stat_o.clr_last    = clr_q == PW'(NUM_PAGES - 1);
    stat_o.init_more   = b_q < e_q;
    stat_o.init_fit    = (32'(b_q) + (32'd1 << ik_q)) <= 32'(e_q);
    stat_o.can_try     = ((32'(k_q) + 32'd1) < NUM_ORDERS) && (buddy32 < NUM_PAGES);
    stat_o.buddy_match = rd_meta.fhead && (rd_meta.order == k_q);
    stat_o.alloc_fail  = want_bad || !found;
    stat_o.k_gt_want   = k_q > want_q;
    stat_o.idx_bad     = 32'(idx_q) >= NUM_PAGES;
    stat_o.page_used   = rd_meta.used;
    stat_o.out_busy    = out_valid_q && out_stall_i;
  end

  // memory port selection
  always_comb begin
    m_we   = 1'b0;
    m_addr = '0;
    m_wd   = '0;
    n_we   = 1'b0;
    n_addr = '0;
    n_wd   = '0;
    v_we   = 1'b0;
    v_addr = '0;
    v_wd   = '0;
    case (op_i)
      OP_CLR: begin
        m_we   = 1'b1;
        m_addr = clr_q[AW-1:0];
      end
      OP_R_READ: begin
        m_addr = buddy[AW-1:0];
        n_addr = buddy[AW-1:0];
        v_addr = buddy[AW-1:0];
      end
      OP_R_UNLINK: begin
        m_we   = 1'b1;
        m_addr = buddy[AW-1:0];
        m_wd   = '{used: 1'b0, fhead: 1'b0, order: k_q};
        n_we   = rd_prev != NIL;
        n_addr = rd_prev[AW-1:0];
        n_wd   = rd_next;
        v_we   = rd_next != NIL;
        v_addr = rd_next[AW-1:0];
        v_wd   = rd_prev;
      end
      OP_PUSH1: begin
        m_we   = 1'b1;
        m_addr = p_q[AW-1:0];
        m_wd   = '{used: 1'b0, fhead: 1'b1, order: k_q};
        n_we   = 1'b1;
        n_addr = p_q[AW-1:0];
        n_wd   = head_k;
        v_we   = 1'b1;
        v_addr = p_q[AW-1:0];
        v_wd   = NIL;
      end
      OP_PUSH2: begin
        v_we   = h_q != NIL;
        v_addr = h_q[AW-1:0];
        v_wd   = p_q;
      end
      OP_A_READ: begin
        m_addr = p_q[AW-1:0];
        n_addr = p_q[AW-1:0];
        v_addr = p_q[AW-1:0];
      end
      OP_A_UNLINK: begin
        m_we   = 1'b1;
        m_addr = p_q[AW-1:0];
        m_wd   = '{used: 1'b1, fhead: 1'b0, order: want_q};
        n_we   = rd_prev != NIL;
        n_addr = rd_prev[AW-1:0];
        n_wd   = rd_next;
        v_we   = rd_next != NIL;
        v_addr = rd_next[AW-1:0];
        v_wd   = rd_prev;
      end
      OP_F_READ: begin
        m_addr = idx_a;
      end
      OP_F_CLEAR: begin
        m_we   = 1'b1;
        m_addr = idx_a;
        m_wd   = '{used: 1'b0, fhead: rd_meta.fhead, order: rd_meta.order};
      end
      default: begin
      end
    endcase
  end

  // page flags and order
  bpa_ram #(.WIDTH(MW), .DEPTH(NUM_PAGES)) u_meta_ram (
    .clk_i  (clk_i),
    .we_i   (m_we),
    .addr_i (m_addr),
    .wdata_i(m_wd),
    .rdata_o(m_rd)
  );

  // free list forward links
  bpa_ram #(.WIDTH(PW), .DEPTH(NUM_PAGES)) u_next_ram (
    .clk_i  (clk_i),
    .we_i   (n_we),
    .addr_i (n_addr),
    .wdata_i(n_wd),
    .rdata_o(rd_next)
  );

  // free list backward links
  bpa_ram #(.WIDTH(PW), .DEPTH(NUM_PAGES)) u_prev_ram (
    .clk_i  (clk_i),
    .we_i   (v_we),
    .addr_i (v_addr),
    .wdata_i(v_wd),
    .rdata_o(rd_prev)
  );

  // datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      begin_q     <= '0;
      end_q       <= REGION_END_RST;
      cmd_q       <= '0;
      cnt_q       <= '0;
      idx_q       <= '0;
      clr_q       <= '0;
      b_q         <= '0;
      e_q         <= '0;
      ik_q        <= '0;
      p_q         <= '0;
      k_q         <= '0;
      want_q      <= '0;
      base_q      <= '0;
      h_q         <= '0;
      for (int i = 0; i < NUM_ORDERS; i++) begin
        head_q[i] <= NIL;
      end
      total_q     <= '0;
      res_st_q    <= '0;
      res_bp_q    <= '0;
      res_bk_q    <= '0;
      out_valid_q <= 1'b0;
      status_q    <= '0;
      bp_q        <= '0;
      bk_q        <= '0;
      fp_q        <= '0;
    end else begin
      // configuration writes
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_REGION_BEGIN: begin_q <= cfg_data_i;
          REG_REGION_END:   end_q   <= cfg_data_i;
          default: begin
          end
        endcase
      end

      // result word taken, unless a new one is loaded in the same cycle
      if (out_valid_q && !out_stall_i && op_i != OP_EMIT) begin
        out_valid_q <= 1'b0;
      end

      case (op_i)
        OP_LOAD: begin
          cmd_q    <= command_i;
          cnt_q    <= page_count_i;
          idx_q    <= page_index_i;
          res_st_q <= ST_OK;
          res_bp_q <= '0;
          res_bk_q <= '0;
          if (command_i == CMD_INIT) begin
            clr_q   <= '0;
            total_q <= '0;
            for (int i = 0; i < NUM_ORDERS; i++) begin
              head_q[i] <= NIL;
            end
          end
        end
        OP_CLR: begin
          clr_q <= clr_q + PW'(1);
        end
        OP_I_BOUNDS: begin
          b_q <= b_clamp;
          e_q <= e_clamp;
        end
        OP_I_TOP: begin
          ik_q <= tz;
        end
        OP_I_DEC: begin
          ik_q <= ik_q - KW'(1);
        end
        OP_I_GO: begin
          p_q <= b_q;
          k_q <= ik_q;
          b_q <= b_q + pow_ik;
        end
        OP_R_UNLINK: begin
          if (rd_prev == NIL) begin
            head_q[k_q] <= rd_next;
          end
          total_q <= total_q - pow_k;
          p_q     <= p_q & buddy;
          k_q     <= k_q + KW'(1);
        end
        OP_PUSH1: begin
          h_q         <= head_k;
          head_q[k_q] <= p_q;
          total_q     <= total_q + pow_k;
        end
        OP_PUSH2: begin
          if (cmd_q == CMD_FREE) begin
            res_bp_q <= IDX_W'(p_q);
            res_bk_q <= ORD_W'(k_q);
          end
        end
        OP_A_SEARCH: begin
          if (want_bad || !found) begin
            res_st_q <= ST_NO_BLOCK;
          end else begin
            want_q <= KW'(want_c);
            k_q    <= fk;
            p_q    <= head_q[fk];
          end
        end
        OP_A_UNLINK: begin
          if (rd_prev == NIL) begin
            head_q[k_q] <= rd_next;
          end
          total_q  <= total_q - pow_k;
          base_q   <= p_q;
          res_bp_q <= IDX_W'(p_q);
          res_bk_q <= ORD_W'(want_q);
        end
        OP_SPLIT: begin
          k_q <= k_q - KW'(1);
          p_q <= base_q + pow_km1;
        end
        OP_F_READ: begin
          if (32'(idx_q) >= NUM_PAGES) begin
            res_st_q <= ST_NOT_ALLOC;
          end
        end
        OP_F_BAD: begin
          res_st_q <= ST_NOT_ALLOC;
        end
        OP_F_CLEAR: begin
          p_q <= PW'(idx_q);
          k_q <= ord_clamp;
        end
        OP_EMIT: begin
          out_valid_q <= 1'b1;
          status_q    <= res_st_q;
          bp_q        <= res_bp_q;
          bk_q        <= res_bk_q;
          fp_q        <= CNT_W'(total_q);
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign block_page_o  = bp_q;
  assign block_order_o = bk_q;
  assign free_pages_o  = fp_q;

endmodule

@@ sv/bpa_ctrl.sv @@
`timescale 1ns / 1ps

module bpa_ctrl import bpa_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [CMD_W-1:0] command_i,
  output logic             in_stall_o,
  input  dp_stat_t         stat_i,
  output dp_op_e           op_o
);

  typedef enum logic [4:0] {
    S_RST_CLR,
    S_IDLE,
    S_CLR,
    S_I_BOUNDS,
    S_I_TOP,
    S_I_FIT,
    S_R_TRY,
    S_R_CHECK,
    S_P_WRITE,
    S_P_LINK,
    S_A_SEARCH,
    S_A_READ,
    S_A_UNLINK,
    S_A_SPLIT,
    S_F_READ,
    S_F_CHECK,
    S_DONE
  } state_e;

  typedef enum logic [1:0] {
    CTX_INIT,
    CTX_ALLOC,
    CTX_FREE
  } ctx_e;

  state_e state_q, state_d;
  ctx_e   ctx_q, ctx_d;

  // next state and micro-operation
  always_comb begin
    state_d = state_q;
    ctx_d   = ctx_q;
    op_o    = OP_IDLE;
    case (state_q)
      S_RST_CLR: begin
        op_o = OP_CLR;
        if (stat_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          op_o = OP_LOAD;
          case (command_i)
            CMD_INIT: begin
              state_d = S_CLR;
              ctx_d   = CTX_INIT;
            end
            CMD_ALLOC: begin
              state_d = S_A_SEARCH;
              ctx_d   = CTX_ALLOC;
            end
            CMD_FREE: begin
              state_d = S_F_READ;
              ctx_d   = CTX_FREE;
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_CLR: begin
        op_o = OP_CLR;
        if (stat_i.clr_last) begin
          state_d = S_I_BOUNDS;
        end
      end
      S_I_BOUNDS: begin
        op_o    = OP_I_BOUNDS;
        state_d = S_I_TOP;
      end
      S_I_TOP: begin
        if (stat_i.init_more) begin
          op_o    = OP_I_TOP;
          state_d = S_I_FIT;
        end else begin
          state_d = S_DONE;
        end
      end
      S_I_FIT: begin
        if (stat_i.init_fit) begin
          op_o    = OP_I_GO;
          state_d = S_R_TRY;
        end else begin
          op_o = OP_I_DEC;
        end
      end
      // merge with the buddy while it is a free head of the same order
      S_R_TRY: begin
        if (stat_i.can_try) begin
          op_o    = OP_R_READ;
          state_d = S_R_CHECK;
        end else begin
          state_d = S_P_WRITE;
        end
      end
      S_R_CHECK: begin
        if (stat_i.buddy_match) begin
          op_o    = OP_R_UNLINK;
          state_d = S_R_TRY;
        end else begin
          state_d = S_P_WRITE;
        end
      end
      S_P_WRITE: begin
        op_o    = OP_PUSH1;
        state_d = S_P_LINK;
      end
      S_P_LINK: begin
        op_o = OP_PUSH2;
        case (ctx_q)
          CTX_INIT:  state_d = S_I_TOP;
          CTX_ALLOC: state_d = S_A_SPLIT;
          default:   state_d = S_DONE;
        endcase
      end
      S_A_SEARCH: begin
        op_o    = OP_A_SEARCH;
        state_d = stat_i.alloc_fail ? S_DONE : S_A_READ;
      end
      S_A_READ: begin
        op_o    = OP_A_READ;
        state_d = S_A_UNLINK;
      end
      S_A_UNLINK: begin
        op_o    = OP_A_UNLINK;
        state_d = S_A_SPLIT;
      end
      S_A_SPLIT: begin
        if (stat_i.k_gt_want) begin
          op_o    = OP_SPLIT;
          state_d = S_P_WRITE;
        end else begin
          state_d = S_DONE;
        end
      end
      S_F_READ: begin
        op_o    = OP_F_READ;
        state_d = stat_i.idx_bad ? S_DONE : S_F_CHECK;
      end
      S_F_CHECK: begin
        if (stat_i.page_used) begin
          op_o    = OP_F_CLEAR;
          state_d = S_R_TRY;
        end else begin
          op_o    = OP_F_BAD;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!stat_i.out_busy) begin
          op_o    = OP_EMIT;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_RST_CLR;
      ctx_q   <= CTX_INIT;
    end else begin
      state_q <= state_d;
      ctx_q   <= ctx_d;
    end
  end

  assign in_stall_o = state_q != S_IDLE;

endmodule

@@ sv/buddy_page_allocator.sv @@
`timescale 1ns / 1ps

// channel  | handshake                    | payload
// ---------+------------------------------+-------------------------------------------
// input    | in_valid_i / in_stall_o      | command_i, page_count_i, page_index_i
// output   | out_valid_o / out_stall_i    | status_o, block_page_o, block_order_o,
//          |                              | free_pages_o
// config   | cfg_we_i                     | cfg_index_i, cfg_data_i
//
// allocate: search, read and unlink the block, then write and link each split half;
// free: read and check the page, then unlink the buddy per merge step; both use the
// single-port page and link memories; init: clear the page memory, then push each block
// after reset a clearing pass runs with the input stalled
// a word waiting on the output does not hold the input; only its completion waits

module buddy_page_allocator import bpa_pkg::*; #(
  parameter int NUM_PAGES  = NUM_PAGES_DEF,
  parameter int NUM_ORDERS = NUM_ORDERS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [CMD_W-1:0]     command_i,
  input  logic [CNT_W-1:0]     page_count_i,
  input  logic [IDX_W-1:0]     page_index_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [STAT_W-1:0]    status_o,
  output logic [IDX_W-1:0]     block_page_o,
  output logic [ORD_W-1:0]     block_order_o,
  output logic [CNT_W-1:0]     free_pages_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [REG_W-1:0]     cfg_data_i
);

  dp_op_e   op;
  dp_stat_t stat;

  // sequencer
  bpa_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .command_i (command_i),
    .in_stall_o(in_stall_o),
    .stat_i    (stat),
    .op_o      (op)
  );

  // lists, page store and result register
  bpa_dp #(
    .NUM_PAGES (NUM_PAGES),
    .NUM_ORDERS(NUM_ORDERS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .op_i         (op),
    .stat_o       (stat),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .command_i    (command_i),
    .page_count_i (page_count_i),
    .page_index_i (page_index_i),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .status_o     (status_o),
    .block_page_o (block_page_o),
    .block_order_o(block_order_o),
    .free_pages_o (free_pages_o)
  );

endmodule

@@ sv/bpa_chk.sv @@
`timescale 1ns / 1ps

`include "buddy_page_allocator_assert.svh"

module bpa_chk import bpa_pkg::*; #(
  parameter int NUM_PAGES  = NUM_PAGES_DEF,
  parameter int NUM_ORDERS = NUM_ORDERS_DEF
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [STAT_W-1:0] status_o,
  input logic [IDX_W-1:0]  block_page_o,
  input logic [ORD_W-1:0]  block_order_o,
  input logic [CNT_W-1:0]  free_pages_o
);

  // a stalled word stays
  `BPA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

  // a stalled word keeps its fields
  `BPA_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(status_o) && $stable(block_page_o) && $stable(block_order_o) && $stable(free_pages_o))

  // failed requests carry no block
  `BPA_ASSERT_NOW(a_err_no_block, clk_i, rst_ni, out_valid_o && status_o != ST_OK, block_page_o == '0 && block_order_o == '0)

  // reported block order within range
  `BPA_ASSERT_NOW(a_order_range, clk_i, rst_ni, out_valid_o, 32'(block_order_o) < NUM_ORDERS)

endmodule

bind buddy_page_allocator bpa_chk #(
  .NUM_PAGES (NUM_PAGES),
  .NUM_ORDERS(NUM_ORDERS)
) u_bpa_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .status_o     (status_o),
  .block_page_o (block_page_o),
  .block_order_o(block_order_o),
  .free_pages_o (free_pages_o)
);
